@@ rtl/core/smf_pkg.sv @@
// Package for the sliding-window median filter.
// Sizes, sample type and the controller/datapath command and status words.
// No dependencies.
`default_nettype none

package smf_pkg;

    localparam int MAX_WINDOW = 8;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [CNT_W-1:0]           t_cnt;
    typedef logic [LEN_W-1:0]           t_len;

    localparam t_len LEN_RESET = t_len'(3);

    typedef struct packed {
        logic shift;     // take the new sample into the window, start a scan
        logic step;      // test one candidate
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic hit;       // current candidate sits at the median rank
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/core/smf_if.sv @@
// Stream interfaces for the median filter: sample words in, median words out.
// Depends on smf_pkg.
`default_nettype none

interface smf_sample_if;
    import smf_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smf_median_if;
    import smf_pkg::*;
    logic    valid;
    logic    ready;
    t_sample median;
    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

@@ rtl/core/smf_ctrl.sv @@
// Controller for the median filter: accept, scan, hand off to output register.
// Depends on smf_pkg.
`default_nettype none

module smf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output smf_pkg::t_dp_cmd     o_cmd,
    input  wire smf_pkg::t_dp_sts i_sts
);
    import smf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait until the output register is free or being emptied
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

`default_nettype wire

@@ rtl/core/smf_dp.sv @@
// Datapath for the median filter: window shift line, length register,
// rank test of one candidate per cycle, result and output registers.
// Depends on smf_pkg.
`default_nettype none

module smf_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire smf_pkg::t_len     i_cfg_wdata,
    input  wire smf_pkg::t_sample  i_sample,
    input  wire smf_pkg::t_dp_cmd  i_cmd,
    output smf_pkg::t_dp_sts       o_sts,
    output smf_pkg::t_sample       o_median
);
    import smf_pkg::*;

    t_len    r_wlen;
    t_sample r_win [MAX_WINDOW];
    t_cnt    r_len;
    t_cnt    r_tgt;
    t_idx    r_cand;
    t_sample r_res;
    t_sample r_out;

    t_cnt    eff_len;
    t_cnt    eff_tgt;
    t_sample cand;
    t_cnt    pos;

    // length 0 acts as 1, anything above the window depth saturates
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = t_cnt'(1);
        end else if (32'(r_wlen) > 32'(MAX_WINDOW)) begin
            eff_len = t_cnt'(MAX_WINDOW);
        end else begin
            eff_len = t_cnt'(r_wlen);
        end
        eff_tgt = t_cnt'(({1'b0, eff_len} + (CNT_W+1)'(1)) >> 1) - t_cnt'(1);
    end

    // descending position of the candidate: larger entries, plus equal
    // entries at lower window positions
    always_comb begin
        cand = r_win[r_cand];
        pos  = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (t_cnt'(i) < r_len) begin
                if (r_win[i] > cand) begin
                    pos = pos + t_cnt'(1);
                end else if (r_win[i] == cand && t_idx'(i) < r_cand) begin
                    pos = pos + t_cnt'(1);
                end
            end
        end
        o_sts.hit = (pos == r_tgt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_wlen <= i_cfg_wdata;
        end
    end

    // only the first len entries move; deeper entries keep their values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_win[0] <= i_sample;
            for (int i = 1; i < MAX_WINDOW; i++) begin
                if (t_cnt'(i) < eff_len) begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= t_cnt'(1);
            r_tgt  <= '0;
            r_cand <= '0;
        end else if (i_cmd.shift) begin
            r_len  <= eff_len;
            r_tgt  <= eff_tgt;
            r_cand <= '0;
        end else if (i_cmd.step) begin
            r_cand <= r_cand + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && o_sts.hit) begin
            r_res <= cand;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_median = r_out;

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_median_filter.sv @@
// Sliding-window median filter, top level: controller plus datapath.
// Depends on smf_pkg, smf_if, smf_ctrl, smf_dp.
// An accepted sample word passes through SCAN, where the candidates of the
// effective window (length 1..8) are ranked one per cycle until the one at the
// median rank turns up, and DONE, which waits while a full output register is
// stalled, then loads the median into it. New words are taken only in IDLE;
// a finished median waits in the output register while the next one is taken.
// Synchronous active-low reset clears the window, sets length 3, empties output.
`default_nettype none

module sliding_window_median_filter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire smf_pkg::t_len i_cfg_wdata,
    smf_sample_if.sink         i_sample_ch,
    smf_median_if.source       o_median_ch
);
    import smf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;
    t_sample median;

    smf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample_ch.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_median_ch.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    smf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_sample_ch.sample),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_median    (median)
    );

    assign i_sample_ch.ready  = in_ready;
    assign o_median_ch.valid  = out_valid;
    assign o_median_ch.median = median;

endmodule

`default_nettype wire
